// ===== rtl/core/lru_slot_cache_controller_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef LRU_SLOT_CACHE_CONTROLLER_CORE_DEFINES_SVH
`define LRU_SLOT_CACHE_CONTROLLER_CORE_DEFINES_SVH
// Same-cycle implication, sampled on clk, off during reset.
`define LSC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsc assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define LSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsc assertion failed");
`endif

// ===== rtl/core/lsc_pkg.sv =====
// ---------------------------------------------------------------------------
// lsc_pkg
// Shared constants, command codes and control types of the slot controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package lsc_pkg;

	localparam int NUM_SLOTS_DEF   = 128;
	localparam int MAX_KEY_LEN_DEF = 1024;
	localparam int KEY_BITS_DEF    = 64;
	localparam int STAMP_BITS_DEF  = 64;
	localparam logic [7:0] CAP_RESET = 8'd64;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_TRIM   = 2'd1,
		CMD_CLEAR  = 2'd2
	} lsc_cmd_code_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_CHECK,
		S_EVICT,
		S_RESULT
	} lsc_state_t;

	// Flags riding the scan wave from cell to cell.
	typedef struct packed {
		logic go;
		logic match_found;
		logic empty_found;
		logic lru_found;
	} lsc_flags_t;

	// Broadcast update to all cells.
	typedef struct packed {
		logic wr_new;
		logic wr_stamp;
		logic inval;
		logic clear;
	} lsc_upd_t;

endpackage

// ===== rtl/core/lsc_if.sv =====
// ---------------------------------------------------------------------------
// lsc_req_if / lsc_rsp_if
// Valid/ready channels for requests and results of the slot controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
interface lsc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [63:0] key_id;
	logic [10:0] key_length;
	logic [15:0] width_key;
	modport source (output valid, command, key_id, key_length, width_key, input ready);
	modport sink (input valid, command, key_id, key_length, width_key, output ready);
endinterface

interface lsc_rsp_if;
	logic       valid;
	logic       ready;
	logic       hit;
	logic       bypass;
	logic       fill_needed;
	logic [6:0] slot_index;
	logic       replaced;
	logic [7:0] evicted_count;
	logic [7:0] occupancy;
	modport source (output valid, hit, bypass, fill_needed, slot_index, replaced,
		evicted_count, occupancy, input ready);
	modport sink (input valid, hit, bypass, fill_needed, slot_index, replaced,
		evicted_count, occupancy, output ready);
endinterface

// ===== rtl/core/lsc_cell.sv =====
// ---------------------------------------------------------------------------
// lsc_cell
// One slot of the store plus one stage of the scan chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module lsc_cell #(
	parameter int NUM_SLOTS  = lsc_pkg::NUM_SLOTS_DEF,
	parameter int KEY_BITS   = lsc_pkg::KEY_BITS_DEF,
	parameter int STAMP_BITS = lsc_pkg::STAMP_BITS_DEF,
	parameter int SLOT       = 0,
	localparam int IDX_W     = $clog2(NUM_SLOTS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lsc_pkg::lsc_upd_t     upd,
	input  logic [IDX_W-1:0]      upd_idx,
	input  logic [KEY_BITS-1:0]   upd_key,
	input  logic [15:0]           upd_width,
	input  logic [STAMP_BITS-1:0] upd_stamp,
	input  logic [KEY_BITS-1:0]   look_key,
	input  logic [15:0]           look_width,
	input  lsc_pkg::lsc_flags_t   flags_i,
	input  logic [IDX_W-1:0]      match_idx_i,
	input  logic [IDX_W-1:0]      empty_idx_i,
	input  logic [IDX_W-1:0]      lru_idx_i,
	input  logic [STAMP_BITS-1:0] lru_stamp_i,
	output lsc_pkg::lsc_flags_t   flags_q,
	output logic [IDX_W-1:0]      match_idx_q,
	output logic [IDX_W-1:0]      empty_idx_q,
	output logic [IDX_W-1:0]      lru_idx_q,
	output logic [STAMP_BITS-1:0] lru_stamp_q
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(SLOT);

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [15:0]           width_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic                  sel;
	logic                  take_match;
	logic                  take_empty;
	logic                  take_lru;

	assign sel        = (upd_idx == MY_IDX);
	assign take_match = valid_q && !flags_i.match_found && key_q == look_key
		&& width_q == look_width;
	assign take_empty = !valid_q && !flags_i.empty_found;
	assign take_lru   = valid_q && (!flags_i.lru_found || stamp_q < lru_stamp_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd.clear) begin
			valid_q <= 1'b0;
		end else if (sel && upd.inval) begin
			valid_q <= 1'b0;
		end else if (sel && upd.wr_new) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sel && upd.wr_new) begin
			key_q   <= upd_key;
			width_q <= upd_width;
		end
		if (sel && (upd.wr_new || upd.wr_stamp)) begin
			stamp_q <= upd_stamp;
		end
	end

	// Hand the running scan record to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			flags_q.go          <= flags_i.go;
			flags_q.match_found <= flags_i.match_found || take_match;
			flags_q.empty_found <= flags_i.empty_found || take_empty;
			flags_q.lru_found   <= flags_i.lru_found || take_lru;
		end
	end

	always_ff @(posedge clk) begin
		match_idx_q <= take_match ? MY_IDX : match_idx_i;
		empty_idx_q <= take_empty ? MY_IDX : empty_idx_i;
		lru_idx_q   <= take_lru ? MY_IDX : lru_idx_i;
		lru_stamp_q <= take_lru ? stamp_q : lru_stamp_i;
	end

endmodule

// ===== rtl/core/lru_slot_cache_controller_core.sv =====
// ---------------------------------------------------------------------------
// lru_slot_cache_controller_core
// Fully associative slot store controller with timestamp LRU replacement.
// ---------------------------------------------------------------------------
// Requests arrive on req (command, key_id, key_length, width_key) and each
// gives exactly one result on rsp. The cap register is written through
// cfg_we/cfg_wdata; the user must do so only while the block is idle, as
// the block itself does not enforce this. Slots form a chain of NUM_SLOTS
// cells; a scan record enters cell 0 and passes through the registered
// cells to the tail, collecting the first match, the first empty slot and
// the LRU slot. A bypass, clear or unused code goes straight to the result;
// a hit takes one scan; a miss takes one scan and then a cap check, and a
// trim a cap check, each plus a full scan per eviction.
// One request is in work at a time; req.ready is high only while idle.
// A finished result waits in the rsp register, so a new request is taken
// while rsp is stalled; the next result then waits until rsp is taken.
// Reset empties all slots, zeroes the use counter and sets the cap to 64.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module lru_slot_cache_controller_core #(
	parameter int NUM_SLOTS   = lsc_pkg::NUM_SLOTS_DEF,
	parameter int MAX_KEY_LEN = lsc_pkg::MAX_KEY_LEN_DEF,
	parameter int KEY_BITS    = lsc_pkg::KEY_BITS_DEF,
	parameter int STAMP_BITS  = lsc_pkg::STAMP_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lsc_req_if.sink    req,
	lsc_rsp_if.source  rsp,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);

	lsc_pkg::lsc_state_t state_q, state_d;
	lsc_pkg::lsc_upd_t   upd;
	logic [IDX_W-1:0]    upd_idx;

	logic [7:0]            cap_q;
	logic [1:0]            cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [15:0]           width_q;
	logic [STAMP_BITS-1:0] ctr_q;
	logic [CNT_W-1:0]      occ_q;
	logic [CNT_W-1:0]      ev_q;
	logic                  inj_q;

	logic       r_hit_q, r_byp_q, r_fill_q, r_repl_q;
	logic [6:0] r_idx_q;

	lsc_pkg::lsc_flags_t   flags_w [NUM_SLOTS+1];
	logic [IDX_W-1:0]      match_w [NUM_SLOTS+1];
	logic [IDX_W-1:0]      empty_w [NUM_SLOTS+1];
	logic [IDX_W-1:0]      lru_w   [NUM_SLOTS+1];
	logic [STAMP_BITS-1:0] lstamp_w[NUM_SLOTS+1];

	lsc_pkg::lsc_flags_t tail;
	logic                accept;
	logic                is_bypass;
	logic                over_cap;
	logic [31:0]         cap_eff;
	logic [IDX_W-1:0]    miss_slot;

	assign tail      = flags_w[NUM_SLOTS];
	assign accept    = req.valid && req.ready;
	assign is_bypass = (req.key_length == 11'd0)
		|| (32'(req.key_length) >= 32'(MAX_KEY_LEN));
	assign cap_eff   = (cap_q == 8'd0) ? 32'd1
		: ((32'(cap_q) > 32'(NUM_SLOTS)) ? 32'(NUM_SLOTS) : 32'(cap_q));
	assign over_cap  = 32'(occ_q) > cap_eff;
	assign miss_slot = tail.empty_found ? empty_w[NUM_SLOTS]
		: (tail.lru_found ? lru_w[NUM_SLOTS] : '0);

	// Scan record injected at the head of the chain.
	assign flags_w[0]  = '{go: inj_q, match_found: 1'b0, empty_found: 1'b0, lru_found: 1'b0};
	assign match_w[0]  = '0;
	assign empty_w[0]  = '0;
	assign lru_w[0]    = '0;
	assign lstamp_w[0] = '0;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		lsc_cell #(
			.NUM_SLOTS (NUM_SLOTS),
			.KEY_BITS  (KEY_BITS),
			.STAMP_BITS(STAMP_BITS),
			.SLOT      (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.upd        (upd),
			.upd_idx    (upd_idx),
			.upd_key    (key_q),
			.upd_width  (width_q),
			.upd_stamp  (ctr_q + STAMP_BITS'(1)),
			.look_key   (key_q),
			.look_width (width_q),
			.flags_i    (flags_w[i]),
			.match_idx_i(match_w[i]),
			.empty_idx_i(empty_w[i]),
			.lru_idx_i  (lru_w[i]),
			.lru_stamp_i(lstamp_w[i]),
			.flags_q    (flags_w[i+1]),
			.match_idx_q(match_w[i+1]),
			.empty_idx_q(empty_w[i+1]),
			.lru_idx_q  (lru_w[i+1]),
			.lru_stamp_q(lstamp_w[i+1])
		);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			lsc_pkg::S_IDLE: begin
				if (accept) begin
					if (req.command == lsc_pkg::CMD_LOOKUP && !is_bypass) begin
						state_d = lsc_pkg::S_LOOK;
					end else if (req.command == lsc_pkg::CMD_TRIM) begin
						state_d = lsc_pkg::S_CHECK;
					end else begin
						state_d = lsc_pkg::S_RESULT;
					end
				end
			end
			lsc_pkg::S_LOOK: begin
				if (tail.go) begin
					state_d = tail.match_found ? lsc_pkg::S_RESULT : lsc_pkg::S_CHECK;
				end
			end
			lsc_pkg::S_CHECK: begin
				state_d = over_cap ? lsc_pkg::S_EVICT : lsc_pkg::S_RESULT;
			end
			lsc_pkg::S_EVICT: begin
				if (tail.go) begin
					state_d = tail.lru_found ? lsc_pkg::S_CHECK : lsc_pkg::S_RESULT;
				end
			end
			lsc_pkg::S_RESULT: begin
				if (!rsp.valid || rsp.ready) begin
					state_d = lsc_pkg::S_IDLE;
				end
			end
			default: state_d = lsc_pkg::S_IDLE;
		endcase
	end

	// Cell updates and handshake outputs.
	always_comb begin
		upd       = '0;
		upd_idx   = '0;
		req.ready = (state_q == lsc_pkg::S_IDLE);
		case (state_q)
			lsc_pkg::S_IDLE: begin
				upd.clear = accept && req.command == lsc_pkg::CMD_CLEAR;
			end
			lsc_pkg::S_LOOK: begin
				if (tail.go && tail.match_found) begin
					upd.wr_stamp = 1'b1;
					upd_idx      = match_w[NUM_SLOTS];
				end else if (tail.go) begin
					upd.wr_new = 1'b1;
					upd_idx    = miss_slot;
				end
			end
			lsc_pkg::S_EVICT: begin
				upd.inval = tail.go && tail.lru_found;
				upd_idx   = lru_w[NUM_SLOTS];
			end
			default: begin
				upd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsc_pkg::S_IDLE;
			cap_q   <= lsc_pkg::CAP_RESET;
			ctr_q   <= '0;
			occ_q   <= '0;
			ev_q    <= '0;
			inj_q   <= 1'b0;
			rsp.valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			// Load a new result in S_RESULT, else drop a taken one.
			rsp.valid <= (state_q == lsc_pkg::S_RESULT) ? 1'b1
				: (rsp.ready ? 1'b0 : rsp.valid);
			case (state_q)
				lsc_pkg::S_IDLE: begin
					ev_q <= '0;
					if (accept && req.command == lsc_pkg::CMD_CLEAR) begin
						ctr_q <= '0;
						occ_q <= '0;
					end
					inj_q <= accept && req.command == lsc_pkg::CMD_LOOKUP && !is_bypass;
				end
				lsc_pkg::S_LOOK: begin
					inj_q <= 1'b0;
					if (tail.go) begin
						ctr_q <= ctr_q + STAMP_BITS'(1);
						if (!tail.match_found && tail.empty_found) begin
							occ_q <= occ_q + CNT_W'(1);
						end
					end
				end
				lsc_pkg::S_CHECK: begin
					inj_q <= over_cap;
				end
				lsc_pkg::S_EVICT: begin
					inj_q <= 1'b0;
					if (tail.go && tail.lru_found) begin
						occ_q <= occ_q - CNT_W'(1);
						ev_q  <= ev_q + CNT_W'(1);
					end
				end
				lsc_pkg::S_RESULT: begin
					inj_q <= 1'b0;
				end
				default: begin
					inj_q <= 1'b0;
				end
			endcase
		end
	end

	// Request and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= req.command;
			key_q    <= req.key_id[KEY_BITS-1:0];
			width_q  <= req.width_key;
			r_hit_q  <= 1'b0;
			r_byp_q  <= req.command == lsc_pkg::CMD_LOOKUP && is_bypass;
			r_fill_q <= 1'b0;
			r_repl_q <= 1'b0;
			r_idx_q  <= '0;
		end
		if (state_q == lsc_pkg::S_LOOK && tail.go) begin
			r_hit_q  <= tail.match_found;
			r_fill_q <= !tail.match_found;
			r_repl_q <= !tail.match_found && !tail.empty_found;
			r_idx_q  <= 7'(tail.match_found ? match_w[NUM_SLOTS] : miss_slot);
		end
		if (state_q == lsc_pkg::S_RESULT && (!rsp.valid || rsp.ready)) begin
			rsp.hit           <= r_hit_q;
			rsp.bypass        <= r_byp_q;
			rsp.fill_needed   <= r_fill_q;
			rsp.slot_index    <= (cmd_q == lsc_pkg::CMD_LOOKUP) ? r_idx_q : 7'd0;
			rsp.replaced      <= r_repl_q;
			rsp.evicted_count <= (32'(ev_q) > 32'd255) ? 8'hFF : 8'(ev_q);
			rsp.occupancy     <= (32'(occ_q) > 32'd255) ? 8'hFF : 8'(occ_q);
		end
	end

endmodule

// ===== rtl/core/lsc_chk.sv =====
// ---------------------------------------------------------------------------
// lsc_chk
// Port-level checks of the slot controller, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_slot_cache_controller_core_defines.svh"
module lsc_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       rsp_hit,
	input logic       rsp_bypass,
	input logic       rsp_fill,
	input logic       rsp_replaced,
	input logic [7:0] rsp_evicted,
	input logic [7:0] rsp_index
);
	`LSC_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_index))
	`LSC_ASSERT_NOW(a_excl, rsp_valid, !(rsp_hit && rsp_bypass) && !(rsp_fill && (rsp_hit || rsp_bypass)))
	`LSC_ASSERT_NOW(a_noev, rsp_valid && (rsp_hit || rsp_bypass), rsp_evicted == 8'd0)
	`LSC_ASSERT_NOW(a_repl, rsp_valid && rsp_replaced, rsp_fill)
endmodule

bind lru_slot_cache_controller_core lsc_chk u_lsc_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_hit     (rsp.hit),
	.rsp_bypass  (rsp.bypass),
	.rsp_fill    (rsp.fill_needed),
	.rsp_replaced(rsp.replaced),
	.rsp_evicted (rsp.evicted_count),
	.rsp_index   ({1'b0, rsp.slot_index})
);

// ===== verif/tb_lru_slot_cache_controller_core.sv =====
// ---------------------------------------------------------------------------
// tb_lru_slot_cache_controller_core
// Self-checking bench for the LRU slot controller: drives lookup, trim,
// clear and unused commands under random handshake gaps, predicts every
// result with a local model of the slot store, and compares all its fields.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_lru_slot_cache_controller_core;

	localparam int SLOTS = lsc_pkg::NUM_SLOTS_DEF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic       hit;
		logic       bypass;
		logic       fill_needed;
		logic [6:0] slot_index;
		logic       replaced;
		logic [7:0] evicted_count;
		logic [7:0] occupancy;
	} slot_result_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	lsc_req_if req ();
	lsc_rsp_if rsp ();

	lru_slot_cache_controller_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req.sink),
		.rsp       (rsp.source),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Local copy of the slot store
	logic        occ_valid [SLOTS];
	logic [63:0] occ_key   [SLOTS];
	logic [15:0] occ_width [SLOTS];
	logic [63:0] occ_stamp [SLOTS];
	logic [63:0] stamp_ctr;
	logic [7:0]  cap_reg;

	slot_result_t pending_results[$];
	int           mismatches;
	longint       cycles;
	bit           quiet;       // no gaps on either side
	int           hold_left;   // long receiver hold-off
	logic [63:0]  key_pool [256];
	logic [15:0]  width_pool [4];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int occupied_slots();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			if (occ_valid[i])
				n++;
		return n;
	endfunction

	function automatic int oldest_slot();
		int pick;
		pick = -1;
		for (int i = 0; i < SLOTS; i++)
			if (occ_valid[i] && (pick < 0 || occ_stamp[i] < occ_stamp[pick]))
				pick = i;
		return pick;
	endfunction

	function automatic int apply_cap();
		int limit;
		int occ;
		int ev;
		int v;
		limit = (cap_reg == 0) ? 1 : ((cap_reg > SLOTS) ? SLOTS : cap_reg);
		occ = occupied_slots();
		ev = 0;
		while (occ > limit) begin
			v = oldest_slot();
			occ_valid[v] = 1'b0;
			occ--;
			ev++;
		end
		return ev;
	endfunction

	function automatic slot_result_t predict_slot_result(logic [1:0] cmd, logic [63:0] key,
			logic [10:0] len, logic [15:0] wid);
		slot_result_t r;
		int found;
		int s;
		r = '0;
		if (cmd == lsc_pkg::CMD_LOOKUP) begin
			if (len == 0 || len >= lsc_pkg::MAX_KEY_LEN_DEF) begin
				r.bypass = 1'b1;
			end else begin
				found = -1;
				for (int i = 0; i < SLOTS && found < 0; i++)
					if (occ_valid[i] && occ_width[i] == wid && occ_key[i] == key)
						found = i;
				if (found >= 0) begin
					r.hit = 1'b1;
					r.slot_index = found[6:0];
					stamp_ctr++;
					occ_stamp[found] = stamp_ctr;
				end else begin
					s = -1;
					for (int i = 0; i < SLOTS && s < 0; i++)
						if (!occ_valid[i])
							s = i;
					if (s < 0) begin
						s = oldest_slot();
						r.replaced = 1'b1;
					end
					stamp_ctr++;
					occ_key[s] = key;
					occ_width[s] = wid;
					occ_stamp[s] = stamp_ctr;
					occ_valid[s] = 1'b1;
					r.fill_needed = 1'b1;
					r.slot_index = s[6:0];
					r.evicted_count = 8'(apply_cap());
				end
			end
		end else if (cmd == lsc_pkg::CMD_TRIM) begin
			r.evicted_count = 8'(apply_cap());
		end else if (cmd == lsc_pkg::CMD_CLEAR) begin
			for (int i = 0; i < SLOTS; i++)
				occ_valid[i] = 1'b0;
			stamp_ctr = '0;
		end
		r.occupancy = 8'(occupied_slots());
		return r;
	endfunction

	task automatic idle_gap();
		int n;
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 55)
			n = 0;
		else if (roll < 92)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(10, 80);
		if (n > 0) begin
			req.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_request(logic [1:0] cmd, logic [63:0] key, logic [10:0] len,
			logic [15:0] wid);
		req.valid      <= 1'b1;
		req.command    <= cmd;
		req.key_id     <= key;
		req.key_length <= len;
		req.width_key  <= wid;
		do
			@(posedge clk);
		while (!req.ready);
		pending_results.push_back(predict_slot_result(cmd, key, len, wid));
		idle_gap();
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cap(logic [7:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_reg = v;
		@(posedge clk);
	endtask

	// Mostly cacheable lookups drawn from a key pool so hits recur
	task automatic random_traffic(int count, int pool_n);
		int roll;
		logic [1:0]  cmd;
		logic [10:0] len;
		logic [15:0] wid;
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			cmd = (roll < 90) ? lsc_pkg::CMD_LOOKUP : (roll < 96) ? lsc_pkg::CMD_TRIM :
				(roll < 98) ? lsc_pkg::CMD_CLEAR : CMD_UNUSED;
			len = ($urandom_range(0, 99) < 8) ?
				(($urandom_range(0, 1) == 0) ? 11'd0 : 11'($urandom_range(1024, 2047))) :
				11'($urandom_range(1, 1023));
			wid = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
				width_pool[$urandom_range(0, 3)];
			send_request(cmd, key_pool[$urandom_range(0, pool_n - 1)], len, wid);
		end
	endtask

	task automatic test_directed();
		send_request(lsc_pkg::CMD_LOOKUP, 64'd1, 11'd0, 16'd0);        // zero length
		send_request(lsc_pkg::CMD_LOOKUP, 64'd1, 11'd1024, 16'd0);     // length at limit
		send_request(lsc_pkg::CMD_LOOKUP, 64'd1, 11'd2047, 16'hFFFF);  // length beyond limit
		send_request(lsc_pkg::CMD_LOOKUP, 64'd0, 11'd1, 16'd0);        // miss into slot 0
		send_request(lsc_pkg::CMD_LOOKUP, 64'd0, 11'd1023, 16'd0);     // hit
		send_request(lsc_pkg::CMD_LOOKUP, 64'd0, 11'd5, 16'hFFFF);     // same key, other width
		send_request(lsc_pkg::CMD_LOOKUP, '1, 11'd1023, 16'hFFFF);
		send_request(lsc_pkg::CMD_LOOKUP, '1, 11'd1023, 16'hFFFF);
		send_request(CMD_UNUSED, '1, 11'd7, 16'd3);
		send_request(lsc_pkg::CMD_TRIM, 64'd0, 11'd0, 16'd0);
		send_request(lsc_pkg::CMD_CLEAR, 64'd0, 11'd0, 16'd0);
		send_request(lsc_pkg::CMD_LOOKUP, '1, 11'd1023, 16'hFFFF);    // miss after clear
		write_cap(8'd2);
		send_request(lsc_pkg::CMD_LOOKUP, 64'h5555_5555_5555_5555, 11'd9, 16'h5555);
		send_request(lsc_pkg::CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 11'd9, 16'hAAAA); // evicts
		write_cap(8'd0);                                                // clamps to one
		send_request(lsc_pkg::CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 11'd9, 16'hAAAA); // no evict
		send_request(lsc_pkg::CMD_TRIM, 64'd0, 11'd0, 16'd0);
		drain();
	endtask

	// Fill every slot, then force replacement of the LRU victim
	task automatic test_full_store();
		write_cap(8'd255);
		send_request(lsc_pkg::CMD_CLEAR, 64'd0, 11'd0, 16'd0);
		for (int i = 0; i < SLOTS + 8; i++)
			send_request(lsc_pkg::CMD_LOOKUP, key_pool[i], 11'd100, width_pool[0]);
		random_traffic(120, 200);
		write_cap(8'd128);
		random_traffic(60, 180);
		write_cap(8'd1);
		send_request(lsc_pkg::CMD_TRIM, 64'd0, 11'd0, 16'd0);          // large eviction
		drain();
	endtask

	task automatic test_backpressure();
		write_cap(8'd16);
		quiet = 1'b1;
		hold_left = 600;
		random_traffic(20, 24);
		quiet = 1'b0;
		drain();                                                  // sender waits it out
		random_traffic(20, 24);
	endtask

	task automatic test_random_caps();
		logic [7:0] caps [6];
		caps = '{8'd64, 8'd8, 8'd3, 8'd100, 8'd200, 8'd1};
		foreach (caps[c]) begin
			write_cap(caps[c] == 8'd100 ? 8'($urandom_range(1, 127)) : caps[c]);
			quiet = (c == 2);
			random_traffic(80, (c == 4) ? 160 : 40);
			quiet = 1'b0;
		end
		drain();
	endtask

	// Receiver: random stalls, mostly short, with one long forced hold-off
	always @(posedge clk) begin
		int roll;
		int stall;
		if (hold_left > 0) begin
			rsp.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			roll = $urandom_range(0, 99);
			if (quiet || roll < 70)
				rsp.ready <= 1'b1;
			else if (roll < 97)
				rsp.ready <= 1'b0;
			else begin
				stall = $urandom_range(10, 60);
				hold_left <= stall;
				rsp.ready <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		slot_result_t want;
		slot_result_t got;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			got = '{rsp.hit, rsp.bypass, rsp.fill_needed, rsp.slot_index, rsp.replaced,
				rsp.evicted_count, rsp.occupancy};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		cycles     = 0;
		quiet      = 1'b0;
		hold_left  = 0;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = 8'd0;
		req.valid      = 1'b0;
		req.command    = lsc_pkg::CMD_LOOKUP;
		req.key_id     = '0;
		req.key_length = '0;
		req.width_key  = '0;
		rsp.ready      = 1'b0;
		for (int i = 0; i < SLOTS; i++)
			occ_valid[i] = 1'b0;
		stamp_ctr = '0;
		cap_reg   = lsc_pkg::CAP_RESET;
		foreach (key_pool[i])
			key_pool[i] = {$urandom, $urandom};
		foreach (width_pool[i])
			width_pool[i] = 16'($urandom);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_store();
		test_backpressure();
		test_random_caps();
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lsc_pkg.sv
rtl/core/lsc_if.sv
rtl/core/lsc_cell.sv
rtl/core/lru_slot_cache_controller_core.sv
rtl/core/lsc_chk.sv
verif/tb_lru_slot_cache_controller_core.sv
